// ===== sv/frb_pkg.sv =====
// Shared types, widths and codes of the frame reorder buffer.
package frb_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned RUN_W      = 16;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned SOCK_W     = 16;
  localparam int unsigned HWL_W      = 11;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned MISSED_W   = 16;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [SEQ_W-1:0]    HALF_RANGE = 32'h7FFF_FFFF;
  localparam logic [MISSED_W-1:0] MISSED_MAX = 16'hFFFF;
  localparam logic [HWL_W-1:0]    HWL_RESET  = 11'd768;
  localparam logic [GAP_W-1:0]    GAP_RESET  = 16'd10;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_HWL = 1'b0;
  localparam logic [0:0] REG_GAP = 1'b1;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PUSH_OK       = 2'd0,
    PUSH_OLD      = 2'd1,
    PUSH_TAKEN    = 2'd2,
    PUSH_SAME_RUN = 2'd3
  } push_status_e;

  typedef enum logic [1:0] {
    POP_OK    = 2'd0,
    POP_EMPTY = 2'd1,
    POP_GAPS  = 2'd2
  } pop_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_IDX,
    ST_PUSH_EVAL,
    ST_POP_SCAN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic [HWL_W-1:0] high_water_level;
    logic [GAP_W-1:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic                operation;
    logic                table_select;
    logic [SEQ_W-1:0]    seq_num;
    logic [RUN_W-1:0]    run_num;
    logic [HANDLE_W-1:0] frame_handle;
    logic [SIZE_W-1:0]   frame_size;
    logic [SOCK_W-1:0]   socket_id;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   push_status;
    logic [STATUS_W-1:0]   pop_status;
    logic [SEQ_W-1:0]      out_seq_num;
    logic [HANDLE_W-1:0]   out_frame_handle;
    logic [SIZE_W-1:0]     out_frame_size;
    logic [SOCK_W-1:0]     out_socket_id;
    logic                  out_table;
    logic [SLOT_OUT_W-1:0] out_slot_index;
    logic                  high_water_flag;
    logic [MISSED_W-1:0]   missed_frames;
    logic                  table_empty;
  } res_t;

  // Contents of one slot of the descriptor memory.
  typedef struct packed {
    logic [SEQ_W-1:0]    seq;
    logic [RUN_W-1:0]    run;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   length;
    logic [SOCK_W-1:0]   source;
  } slot_t;

  // Access controls from the sequencer to the slot memories.
  typedef struct packed {
    logic       rd_en;
    logic       rd_tbl;
    logic       v_we;
    logic [1:0] v_wrow;
    logic       p_we;
    logic       wr_tbl;
  } mem_ctl_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } stat_t;

endpackage

// ===== sv/frb_in_if.sv =====
// Input item channel of the frame reorder buffer.
interface frb_in_if;
  import frb_pkg::*;

  logic                valid;
  logic                ready;
  logic                operation;
  logic                table_select;
  logic [SEQ_W-1:0]    seq_num;
  logic [RUN_W-1:0]    run_num;
  logic [HANDLE_W-1:0] frame_handle;
  logic [SIZE_W-1:0]   frame_size;
  logic [SOCK_W-1:0]   socket_id;

  modport source (
    output valid, operation, table_select, seq_num, run_num, frame_handle,
           frame_size, socket_id,
    input  ready
  );

  modport sink (
    input  valid, operation, table_select, seq_num, run_num, frame_handle,
           frame_size, socket_id,
    output ready
  );
endinterface

// ===== sv/frb_out_if.sv =====
// Result item channel of the frame reorder buffer.
interface frb_out_if;
  import frb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   push_status;
  logic [STATUS_W-1:0]   pop_status;
  logic [SEQ_W-1:0]      out_seq_num;
  logic [HANDLE_W-1:0]   out_frame_handle;
  logic [SIZE_W-1:0]     out_frame_size;
  logic [SOCK_W-1:0]     out_socket_id;
  logic                  out_table;
  logic [SLOT_OUT_W-1:0] out_slot_index;
  logic                  high_water_flag;
  logic [MISSED_W-1:0]   missed_frames;
  logic                  table_empty;

  modport source (
    output valid, push_status, pop_status, out_seq_num, out_frame_handle,
           out_frame_size, out_socket_id, out_table, out_slot_index,
           high_water_flag, missed_frames, table_empty,
    input  ready
  );

  modport sink (
    input  valid, push_status, pop_status, out_seq_num, out_frame_handle,
           out_frame_size, out_socket_id, out_table, out_slot_index,
           high_water_flag, missed_frames, table_empty,
    output ready
  );
endinterface

// ===== sv/frb_cfg_regs.sv =====
// APB-style configuration registers of the frame reorder buffer.
module frb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [frb_pkg::PADDR_W-1:0]  paddr,
  input  logic [frb_pkg::PDATA_W-1:0]  pwdata,
  output logic [frb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output frb_pkg::cfg_t                cfg_o
);
  import frb_pkg::*;

  logic [HWL_W-1:0] hwl_q;
  logic [GAP_W-1:0] gap_q;
  logic [0:0]       reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hwl_q <= HWL_RESET;
      gap_q <= GAP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HWL: hwl_q <= pwdata[HWL_W-1:0];
        REG_GAP: gap_q <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HWL: prdata = {{(PDATA_W-HWL_W){1'b0}}, hwl_q};
      REG_GAP: prdata = {{(PDATA_W-GAP_W){1'b0}}, gap_q};
      default: prdata = '0;
    endcase
  end

  assign cfg_o.high_water_level = hwl_q;
  assign cfg_o.gap_limit        = gap_q;

endmodule

// ===== sv/frb_idx_mod.sv =====
// Reduces a sequence number to its slot index, modulo the table depth.
module frb_idx_mod #(
  parameter int unsigned DEPTH = frb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [frb_pkg::SEQ_W-1:0] value_i,
  output logic                      done_o,
  output logic [$clog2(DEPTH)-1:0]  idx_o
);
  import frb_pkg::*;

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam bit          IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

  if (IS_POW2) begin : g_mask
    logic [IDX_W-1:0] idx_q;
    logic             done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= value_i[IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end else begin : g_recip
    // Quotient by a rounded-up reciprocal of the depth, then the remainder by a
    // multiply back and subtract, one register stage each. The reciprocal has 33
    // bits with the top one set, so the product is the value shifted up by 32
    // plus a 32 by 32 product.
    localparam int unsigned      PROD_W   = 2 * SEQ_W;
    localparam logic [63:0]      RECIP    = ((64'd1 << (SEQ_W + IDX_W)) / 64'(DEPTH)) + 64'd1;
    localparam logic [SEQ_W-1:0] RECIP_LO = RECIP[SEQ_W-1:0];
    localparam logic [SEQ_W-1:0] DEPTH_C  = SEQ_W'(DEPTH);

    logic [SEQ_W-1:0]  val_q;
    logic [PROD_W:0]   prod_q, prod_d;
    logic [PROD_W-1:0] mul_lo;
    logic [SEQ_W-1:0]  quot;
    logic [SEQ_W-1:0]  back;
    logic [SEQ_W-1:0]  rem;
    logic [IDX_W-1:0]  rem_q;
    logic              st1_q;
    logic              st2_q;
    logic              done_q;

    assign mul_lo = PROD_W'(val_q) * PROD_W'(RECIP_LO);
    assign prod_d = {1'b0, val_q, {SEQ_W{1'b0}}} + {1'b0, mul_lo};
    assign quot   = SEQ_W'(prod_q >> (SEQ_W + IDX_W));
    assign back   = quot * DEPTH_C;
    assign rem    = val_q - back;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st1_q  <= 1'b0;
        st2_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        st1_q  <= start_i;
        st2_q  <= st1_q;
        done_q <= st2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
      end
      if (st1_q) begin
        prod_q <= prod_d;
      end
      if (st2_q) begin
        rem_q <= rem[IDX_W-1:0];
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end

endmodule

// ===== sv/frb_slot_mem.sv =====
// Slot memories: valid bits of both tables by row, and descriptors by table and slot.
module frb_slot_mem #(
  parameter int unsigned DEPTH = frb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  frb_pkg::mem_ctl_t        ctl_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  frb_pkg::slot_t           wr_slot_i,
  output logic [1:0]               rd_row_o,
  output frb_pkg::slot_t           rd_slot_o
);
  import frb_pkg::*;

  logic [1:0] vmem [DEPTH];
  slot_t      pmem [2][DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.v_we) begin
      vmem[wr_idx_i] <= ctl_i.v_wrow;
    end
    if (ctl_i.rd_en) begin
      rd_row_o <= vmem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.p_we) begin
      pmem[ctl_i.wr_tbl][wr_idx_i] <= wr_slot_i;
    end
    if (ctl_i.rd_en) begin
      rd_slot_o <= pmem[ctl_i.rd_tbl][rd_idx_i];
    end
  end

endmodule

// ===== sv/frb_ctrl.sv =====
// Sequencer of the frame reorder buffer: table state, push and pop steps, result register.
module frb_ctrl #(
  parameter int unsigned DEPTH = frb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_vld_i,
  output logic                      in_rdy_o,
  input  frb_pkg::in_t              in_data_i,
  output logic                      out_vld_o,
  input  logic                      out_rdy_i,
  output frb_pkg::res_t             out_data_o,
  input  frb_pkg::cfg_t             cfg_i,
  output logic                      mod_start_o,
  input  logic                      mod_done_i,
  input  logic [$clog2(DEPTH)-1:0]  mod_idx_i,
  output frb_pkg::mem_ctl_t         mem_ctl_o,
  output logic [$clog2(DEPTH)-1:0]  mem_rd_idx_o,
  output logic [$clog2(DEPTH)-1:0]  mem_wr_idx_o,
  output frb_pkg::slot_t            mem_wr_slot_o,
  input  logic [1:0]                mem_row_i,
  input  frb_pkg::slot_t            mem_slot_i,
  output frb_pkg::stat_t            stat_o
);
  import frb_pkg::*;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (FILL_W > HWL_W) ? FILL_W : HWL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  ctrl_state_e state_q, state_d;

  logic [IDX_W-1:0]    clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [FILL_W-1:0]   fill_q [2];
  logic [FILL_W-1:0]   fill_d [2];
  logic [IDX_W-1:0]    oldest_idx_q, oldest_idx_d;
  logic [SEQ_W-1:0]    oldest_seq_q, oldest_seq_d;
  logic                oldest_tbl_q, oldest_tbl_d;
  logic                first_q, first_d;
  logic [MISSED_W-1:0] missed_q, missed_d;
  logic                hw_q, hw_d;
  logic                hw_chk_q, hw_chk_d;
  in_t                 item_q, item_d;
  res_t                res_q, res_d;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;

  logic                accept;
  logic [IDX_W-1:0]    idx_next;
  logic [SEQ_W-1:0]    seq_diff;
  logic [MISSED_W-1:0] missed_inc;
  logic [CMP_W-1:0]    level_ext;
  logic [CMP_W-1:0]    fill0_ext;
  logic [CMP_W-1:0]    fill1_ext;
  logic                hw_hit;
  logic [SLOT_OUT_W+IDX_W-1:0] slot_ext;

  assign accept     = in_vld_i && (state_q == ST_IDLE);
  assign idx_next   = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
  assign seq_diff   = oldest_seq_q - item_q.seq_num;
  assign missed_inc = (missed_q != MISSED_MAX) ? missed_q + MISSED_W'(1) : missed_q;
  assign level_ext  = CMP_W'(cfg_i.high_water_level);
  assign fill0_ext  = CMP_W'(fill_q[0]);
  assign fill1_ext  = CMP_W'(fill_q[1]);
  assign hw_hit     = (fill0_ext >= level_ext) || (fill1_ext >= level_ext);
  assign slot_ext   = {{SLOT_OUT_W{1'b0}}, idx_q};

  always_comb begin
    state_d      = state_q;
    clr_idx_d    = clr_idx_q;
    idx_d        = idx_q;
    fill_d[0]    = fill_q[0];
    fill_d[1]    = fill_q[1];
    oldest_idx_d = oldest_idx_q;
    oldest_seq_d = oldest_seq_q;
    oldest_tbl_d = oldest_tbl_q;
    first_d      = first_q;
    missed_d     = missed_q;
    hw_d         = hw_q;
    hw_chk_d     = hw_chk_q;
    item_d       = item_q;
    res_d        = res_q;
    out_vld_d    = out_vld_q && !out_rdy_i;
    out_d        = out_q;
    mod_start_o  = 1'b0;
    mem_ctl_o    = '0;
    mem_rd_idx_o = idx_q;
    mem_wr_idx_o = idx_q;

    case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.v_we   = 1'b1;
        mem_ctl_o.v_wrow = 2'b00;
        mem_wr_idx_o     = clr_idx_q;
        clr_idx_d        = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          item_d   = in_data_i;
          res_d    = '0;
          hw_chk_d = 1'b0;
          if (in_data_i.operation == OP_PUSH) begin
            mod_start_o = 1'b1;
            state_d     = ST_PUSH_IDX;
          end else if (fill_q[oldest_tbl_q] == '0) begin
            res_d.pop_status = POP_EMPTY;
            state_d          = ST_FINISH;
          end else begin
            idx_d            = oldest_idx_q;
            mem_ctl_o.rd_en  = 1'b1;
            mem_ctl_o.rd_tbl = oldest_tbl_q;
            mem_rd_idx_o     = oldest_idx_q;
            state_d          = ST_POP_SCAN;
          end
        end
      end

      ST_PUSH_IDX: begin
        if (mod_done_i) begin
          idx_d = mod_idx_i;
          if (!first_q && (oldest_tbl_q == item_q.table_select) &&
              (seq_diff != '0) && (seq_diff <= HALF_RANGE)) begin
            res_d.push_status = PUSH_OLD;
            state_d           = ST_FINISH;
          end else begin
            mem_ctl_o.rd_en  = 1'b1;
            mem_ctl_o.rd_tbl = item_q.table_select;
            mem_rd_idx_o     = mod_idx_i;
            hw_chk_d         = 1'b1;
            state_d          = ST_PUSH_EVAL;
          end
        end
      end

      ST_PUSH_EVAL: begin
        if (!mem_row_i[item_q.table_select]) begin
          mem_ctl_o.v_we   = 1'b1;
          mem_ctl_o.v_wrow = mem_row_i;
          mem_ctl_o.v_wrow[item_q.table_select] = 1'b1;
          mem_ctl_o.p_we   = 1'b1;
          mem_ctl_o.wr_tbl = item_q.table_select;
          fill_d[item_q.table_select] = fill_q[item_q.table_select] + FILL_W'(1);
          if (first_q) begin
            oldest_idx_d = idx_q;
            oldest_seq_d = item_q.seq_num;
            oldest_tbl_d = item_q.table_select;
            first_d      = 1'b0;
          end
          res_d.push_status = PUSH_OK;
        end else if ((mem_slot_i.run == item_q.run_num) &&
                     (mem_slot_i.seq < item_q.seq_num)) begin
          res_d.push_status = PUSH_SAME_RUN;
        end else begin
          res_d.push_status = PUSH_TAKEN;
        end
        state_d = ST_FINISH;
      end

      ST_POP_SCAN: begin
        if (mem_row_i[oldest_tbl_q]) begin
          mem_ctl_o.v_we   = 1'b1;
          mem_ctl_o.v_wrow = mem_row_i;
          mem_ctl_o.v_wrow[oldest_tbl_q] = 1'b0;
          fill_d[oldest_tbl_q]   = fill_q[oldest_tbl_q] - FILL_W'(1);
          res_d.pop_status       = POP_OK;
          res_d.out_seq_num      = mem_slot_i.seq;
          res_d.out_frame_handle = mem_slot_i.handle;
          res_d.out_frame_size   = mem_slot_i.length;
          res_d.out_socket_id    = mem_slot_i.source;
          res_d.out_table        = oldest_tbl_q;
          res_d.out_slot_index   = slot_ext[SLOT_OUT_W-1:0];
          oldest_seq_d           = mem_slot_i.seq + SEQ_W'(1);
          oldest_idx_d           = idx_next;
          state_d                = ST_FINISH;
        end else begin
          missed_d = missed_inc;
          if (missed_inc > cfg_i.gap_limit) begin
            res_d.pop_status = POP_GAPS;
            state_d          = ST_FINISH;
          end else begin
            idx_d            = idx_next;
            mem_ctl_o.rd_en  = 1'b1;
            mem_ctl_o.rd_tbl = oldest_tbl_q;
            mem_rd_idx_o     = idx_next;
          end
        end
      end

      ST_FINISH: begin
        if (!out_vld_q || out_rdy_i) begin
          hw_d                  = hw_q || (hw_chk_q && hw_hit);
          out_d                 = res_q;
          out_d.high_water_flag = hw_q || (hw_chk_q && hw_hit);
          out_d.missed_frames   = missed_q;
          out_d.table_empty     = (fill_q[item_q.table_select] == '0);
          out_vld_d             = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    mem_wr_slot_o.seq    = item_q.seq_num;
    mem_wr_slot_o.run    = item_q.run_num;
    mem_wr_slot_o.handle = item_q.frame_handle;
    mem_wr_slot_o.length = item_q.frame_size;
    mem_wr_slot_o.source = item_q.socket_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      fill_q[0]    <= '0;
      fill_q[1]    <= '0;
      oldest_idx_q <= '0;
      oldest_seq_q <= '0;
      oldest_tbl_q <= 1'b0;
      first_q      <= 1'b1;
      missed_q     <= '0;
      hw_q         <= 1'b0;
      hw_chk_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_idx_q    <= clr_idx_d;
      fill_q[0]    <= fill_d[0];
      fill_q[1]    <= fill_d[1];
      oldest_idx_q <= oldest_idx_d;
      oldest_seq_q <= oldest_seq_d;
      oldest_tbl_q <= oldest_tbl_d;
      first_q      <= first_d;
      missed_q     <= missed_d;
      hw_q         <= hw_d;
      hw_chk_q     <= hw_chk_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_rdy_o        = (state_q == ST_IDLE);
  assign out_vld_o       = out_vld_q;
  assign out_data_o      = out_q;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.busy     = (state_q != ST_CLEAR) && (state_q != ST_IDLE);

endmodule

// ===== sv/frame_reorder_buffer.sv =====
// Top level of the frame reorder buffer: channels, configuration port and checks.
//
// Items arrive on in_i (valid/ready). A push (operation 0) files a frame descriptor
// into table table_select at slot seq_num mod TABLE_DEPTH; a pop (operation 1)
// returns the held frame with the oldest sequence in the oldest table, skipping
// empty slots. Every item yields exactly one result item on out_o (valid/ready),
// in order. high_water_level and gap_limit sit on the APB-style port at byte
// addresses 0 and 4; write them only while the block is idle.
// One item is worked on at a time; the next one is accepted in the cycle its
// result appears. A push reduces seq_num to a slot index, reads that slot and
// then files the frame or reports why not; one dropped as older than the oldest
// frame skips the read. A pop reads slots from the oldest one on, skipping empty
// ones, until it finds a frame or the missed frame count passes gap_limit, and
// reads nothing on an empty table. Each step is one read of the slot memories,
// whose data is registered. Depths other than a power of two use a reciprocal.
// After reset a clearing pass over every slot wipes the valid bits of both
// tables; in_i.ready stays low meanwhile, while configuration writes are taken.
// The result register lets the next item be accepted and worked on while a result
// waits; if out_o is stalled when a new result is done, the block holds it back.
module frame_reorder_buffer #(
  parameter int unsigned TABLE_DEPTH = frb_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  frb_in_if.sink                      in_i,
  frb_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [frb_pkg::PADDR_W-1:0] paddr,
  input  logic [frb_pkg::PDATA_W-1:0] pwdata,
  output logic [frb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import frb_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  cfg_t             cfg;
  in_t              in_data;
  res_t             out_data;
  stat_t            stat;
  mem_ctl_t         mem_ctl;
  slot_t            wr_slot;
  slot_t            rd_slot;
  logic [1:0]       rd_row;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_idx;
  logic             in_rdy;
  logic             out_vld;

  assign in_data.operation    = in_i.operation;
  assign in_data.table_select = in_i.table_select;
  assign in_data.seq_num      = in_i.seq_num;
  assign in_data.run_num      = in_i.run_num;
  assign in_data.frame_handle = in_i.frame_handle;
  assign in_data.frame_size   = in_i.frame_size;
  assign in_data.socket_id    = in_i.socket_id;
  assign in_i.ready           = in_rdy;

  assign out_o.valid            = out_vld;
  assign out_o.push_status      = out_data.push_status;
  assign out_o.pop_status       = out_data.pop_status;
  assign out_o.out_seq_num      = out_data.out_seq_num;
  assign out_o.out_frame_handle = out_data.out_frame_handle;
  assign out_o.out_frame_size   = out_data.out_frame_size;
  assign out_o.out_socket_id    = out_data.out_socket_id;
  assign out_o.out_table        = out_data.out_table;
  assign out_o.out_slot_index   = out_data.out_slot_index;
  assign out_o.high_water_flag  = out_data.high_water_flag;
  assign out_o.missed_frames    = out_data.missed_frames;
  assign out_o.table_empty      = out_data.table_empty;

  frb_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Slot index of a pushed frame; a mask for power-of-two depths.
  frb_idx_mod #(
    .DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (in_data.seq_num),
    .done_o  (mod_done),
    .idx_o   (mod_idx)
  );

  frb_slot_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_idx_i  (rd_idx),
    .wr_idx_i  (wr_idx),
    .wr_slot_i (wr_slot),
    .rd_row_o  (rd_row),
    .rd_slot_o (rd_slot)
  );

  frb_ctrl #(
    .DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_vld_i      (in_i.valid),
    .in_rdy_o      (in_rdy),
    .in_data_i     (in_data),
    .out_vld_o     (out_vld),
    .out_rdy_i     (out_o.ready),
    .out_data_o    (out_data),
    .cfg_i         (cfg),
    .mod_start_o   (mod_start),
    .mod_done_i    (mod_done),
    .mod_idx_i     (mod_idx),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_idx_o  (rd_idx),
    .mem_wr_idx_o  (wr_idx),
    .mem_wr_slot_o (wr_slot),
    .mem_row_i     (rd_row),
    .mem_slot_i    (rd_slot),
    .stat_o        (stat)
  );

`ifndef SYNTH
  // No item may enter while the valid bits are still being wiped.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !in_i.ready)
    else $error("input item accepted during the clearing pass");

  // A result reports either a push outcome or a pop outcome, never both.
  a_one_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.push_status == PUSH_OK) || (out_o.pop_status == POP_OK))
    else $error("result carries both a push and a pop status");

  // Only a successful pop carries frame fields; all other results show zeros.
  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ((out_o.pop_status != POP_OK) || (out_o.push_status != PUSH_OK)))
    |-> (out_o.out_seq_num == '0) && (out_o.out_frame_handle == '0) &&
        (out_o.out_frame_size == '0) && (out_o.out_socket_id == '0) &&
        (out_o.out_table == 1'b0) && (out_o.out_slot_index == '0))
    else $error("frame fields set on a result without a popped frame");

  // While an item is in work the input side stays closed.
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !in_i.ready)
    else $error("input ready while an item is in work");
`endif

endmodule
